// ===== hdl/mar_pkg.sv =====
`timescale 1ns / 1ps

package mar_pkg;

  // Operand width actually used; the sign bit is bit DataWidth-1.
  localparam int DataWidth = 32;
  // Width of the modulus and of every residue.
  localparam int ModW = 31;
  // Width of a full product of two residues.
  localparam int ProdW = 2 * ModW;
  // Depth of the queue between front and back.
  localparam int QueueDepth = 2;

  typedef enum logic [1:0] {
    OpAdd    = 2'd0,
    OpSub    = 2'd1,
    OpMul    = 2'd2,
    OpReduce = 2'd3
  } op_e;

  // One classified item: operation plus sign and magnitude of each operand.
  typedef struct packed {
    op_e                  op;
    logic                 a_neg;
    logic [DataWidth-1:0] a_mag;
    logic                 b_neg;
    logic [DataWidth-1:0] b_mag;
  } item_t;

  // Head of the queue as seen by the back part.
  typedef struct packed {
    logic  vld;
    item_t item;
  } head_t;

  // One step of a restoring remainder: shift in one bit, subtract if it fits.
  function automatic logic [ModW-1:0] rem_step(input logic [ModW-1:0] rem,
                                               input logic            bit_in,
                                               input logic [ModW-1:0] m);
    logic [ModW:0] t;
    t = {rem, bit_in};
    if (t >= {1'b0, m}) begin
      t = t - {1'b0, m};
    end
    return t[ModW-1:0];
  endfunction

endpackage

// ===== hdl/mar_front.sv =====
`timescale 1ns / 1ps

module mar_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                operation_i,
  input  logic signed [31:0]        operand_a_i,
  input  logic signed [31:0]        operand_b_i,
  input  logic                      pop_i,
  output mar_pkg::head_t            head_o
);

  localparam logic [31:0] OperandMask =
    32'((64'd1 << mar_pkg::DataWidth) - 64'd1);

  mar_pkg::item_t         fifo_q [mar_pkg::QueueDepth];
  logic                   wr_ptr_q, wr_ptr_d;
  logic                   rd_ptr_q, rd_ptr_d;
  logic [1:0]             cnt_q, cnt_d;
  logic                   push, pop, full;
  logic [31:0]            a_v, b_v;
  mar_pkg::item_t         item;

  // Split each operand into sign and magnitude over the used width.
  always_comb begin
    a_v = operand_a_i & OperandMask;
    b_v = operand_b_i & OperandMask;
    item.op    = mar_pkg::op_e'(operation_i);
    item.a_neg = a_v[mar_pkg::DataWidth-1];
    item.b_neg = b_v[mar_pkg::DataWidth-1];
    item.a_mag = item.a_neg ? mar_pkg::DataWidth'((~a_v) + 32'd1)
                            : mar_pkg::DataWidth'(a_v);
    item.b_mag = item.b_neg ? mar_pkg::DataWidth'((~b_v) + 32'd1)
                            : mar_pkg::DataWidth'(b_v);
  end

  // Queue control.
  assign full       = (cnt_q == 2'(mar_pkg::QueueDepth));
  assign in_stall_o = full;
  assign push       = in_valid_i && !full;
  assign pop        = pop_i && (cnt_q != 2'd0);

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= item;
    end
  end

  assign head_o.vld  = (cnt_q != 2'd0);
  assign head_o.item = fifo_q[rd_ptr_q];

endmodule

// ===== hdl/mar_back.sv =====
`timescale 1ns / 1ps

module mar_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [mar_pkg::ModW-1:0]    mod_i,
  input  mar_pkg::head_t              head_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [mar_pkg::ModW-1:0]    result_o
);

  localparam int RedSteps = mar_pkg::DataWidth;
  localparam int MulSteps = mar_pkg::ProdW;

  typedef struct packed {
    mar_pkg::op_e                  op;
    logic [mar_pkg::ModW-1:0]      a_rem;
    logic [mar_pkg::DataWidth-1:0] a_sh;
    logic                          a_neg;
    logic [mar_pkg::ModW-1:0]      b_rem;
    logic [mar_pkg::DataWidth-1:0] b_sh;
    logic                          b_neg;
  } red_t;

  typedef struct packed {
    logic [mar_pkg::ModW-1:0]  rem;
    logic [mar_pkg::ProdW-1:0] sh;
  } mrem_t;

  logic                      adv;
  red_t                      red_q [RedSteps+1];
  logic [RedSteps:0]         red_vld_q;
  mar_pkg::op_e              fix_op_q;
  logic [mar_pkg::ModW-1:0]  fix_a_q, fix_b_q;
  logic                      fix_vld_q;
  logic [mar_pkg::ProdW-1:0] opr_q;
  logic                      opr_vld_q;
  mrem_t                     mr_q [MulSteps+1];
  logic [MulSteps:0]         mr_vld_q;
  logic [mar_pkg::ModW-1:0]  out_q;
  logic                      out_vld_q;
  logic [mar_pkg::ModW-1:0]  fix_a_d, fix_b_d;
  logic [mar_pkg::ModW:0]    sum, dif;
  logic [mar_pkg::ModW-1:0]  addsub;
  logic [mar_pkg::ProdW-1:0] prod, opr_d;
  red_t                      red_in;

  // The whole pipeline moves unless a finished beat waits at the output.
  assign adv   = !(out_vld_q && out_stall_i);
  assign pop_o = adv;

  // Valid bits of every stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_vld_q <= '0;
      fix_vld_q <= 1'b0;
      opr_vld_q <= 1'b0;
      mr_vld_q  <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      red_vld_q <= {red_vld_q[RedSteps-1:0], head_i.vld};
      fix_vld_q <= red_vld_q[RedSteps];
      opr_vld_q <= fix_vld_q;
      mr_vld_q  <= {mr_vld_q[MulSteps-1:0], opr_vld_q};
      out_vld_q <= mr_vld_q[MulSteps];
    end
  end

  // Entry of the operand reduction pipeline.
  always_comb begin
    red_in.op    = head_i.item.op;
    red_in.a_rem = '0;
    red_in.a_sh  = head_i.item.a_mag;
    red_in.a_neg = head_i.item.a_neg;
    red_in.b_rem = '0;
    red_in.b_sh  = head_i.item.b_mag;
    red_in.b_neg = head_i.item.b_neg;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      red_q[0] <= red_in;
    end
  end

  // Operand reduction: one magnitude bit per stage for both operands.
  for (genvar g = 0; g < RedSteps; g++) begin : g_red
    always_ff @(posedge clk_i) begin
      if (adv) begin
        red_q[g+1].op    <= red_q[g].op;
        red_q[g+1].a_neg <= red_q[g].a_neg;
        red_q[g+1].b_neg <= red_q[g].b_neg;
        red_q[g+1].a_rem <= mar_pkg::rem_step(red_q[g].a_rem,
                                              red_q[g].a_sh[mar_pkg::DataWidth-1], mod_i);
        red_q[g+1].b_rem <= mar_pkg::rem_step(red_q[g].b_rem,
                                              red_q[g].b_sh[mar_pkg::DataWidth-1], mod_i);
        red_q[g+1].a_sh  <= red_q[g].a_sh << 1;
        red_q[g+1].b_sh  <= red_q[g].b_sh << 1;
      end
    end
  end

  // Floored residue: a negative value with a non-zero remainder maps to m - r.
  always_comb begin
    fix_a_d = red_q[RedSteps].a_rem;
    fix_b_d = red_q[RedSteps].b_rem;
    if (red_q[RedSteps].a_neg && (fix_a_d != '0)) begin
      fix_a_d = mod_i - red_q[RedSteps].a_rem;
    end
    if (red_q[RedSteps].b_neg && (fix_b_d != '0)) begin
      fix_b_d = mod_i - red_q[RedSteps].b_rem;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fix_op_q <= red_q[RedSteps].op;
      fix_a_q  <= fix_a_d;
      fix_b_q  <= fix_b_d;
    end
  end

  // Operation: add and subtract finish here, reduce passes the first residue, multiply leaves a full product.
  always_comb begin
    sum  = {1'b0, fix_a_q} + {1'b0, fix_b_q};
    dif  = {1'b0, fix_a_q} + {1'b0, mod_i} - {1'b0, fix_b_q};
    prod = mar_pkg::ProdW'(fix_a_q) * mar_pkg::ProdW'(fix_b_q);
    addsub = fix_a_q;
    opr_d  = '0;
    unique case (fix_op_q)
      mar_pkg::OpAdd: begin
        addsub = (sum >= {1'b0, mod_i}) ? mar_pkg::ModW'(sum - {1'b0, mod_i})
                                        : mar_pkg::ModW'(sum);
        opr_d  = mar_pkg::ProdW'(addsub);
      end
      mar_pkg::OpSub: begin
        addsub = (fix_a_q >= fix_b_q) ? (fix_a_q - fix_b_q) : mar_pkg::ModW'(dif);
        opr_d  = mar_pkg::ProdW'(addsub);
      end
      mar_pkg::OpMul: begin
        opr_d = prod;
      end
      default: begin
        opr_d = mar_pkg::ProdW'(fix_a_q);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      opr_q <= opr_d;
    end
  end

  // Final reduction of the wide value; a residue already below m passes unchanged.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      mr_q[0].rem <= '0;
      mr_q[0].sh  <= opr_q;
    end
  end

  for (genvar g = 0; g < MulSteps; g++) begin : g_mr
    always_ff @(posedge clk_i) begin
      if (adv) begin
        mr_q[g+1].rem <= mar_pkg::rem_step(mr_q[g].rem,
                                           mr_q[g].sh[mar_pkg::ProdW-1], mod_i);
        mr_q[g+1].sh  <= mr_q[g].sh << 1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= mr_q[MulSteps].rem;
    end
  end

  assign out_valid_o = out_vld_q;
  assign result_o    = out_q;

endmodule

// ===== hdl/modular_add_sub_mul_top.sv =====
`timescale 1ns / 1ps

// Channel  | Direction | Handshake                   | Beat
// input    | in        | in_valid_i / in_stall_o     | operation_i, operand_a_i, operand_b_i
// output   | out       | out_valid_o / out_stall_i   | result_o
// config   | in        | cfg_valid_i / cfg_ready_o   | cfg_modulus_i
//
// One beat is accepted every cycle while in_stall_o is low; the back is built from the
// bit-per-stage remainder pipelines (DataWidth stages for the operands, 62 for the product).
// Reset clears the modulus to one and empties the queue and every stage.
// An output stall while a result waits freezes the back pipeline; the two-entry queue keeps
// taking beats until it fills, then in_stall_o rises.

module modular_add_sub_mul_top (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               operation_i,
  input  logic signed [31:0]       operand_a_i,
  input  logic signed [31:0]       operand_b_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [30:0]              result_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [30:0]              cfg_modulus_i
);

  logic [mar_pkg::ModW-1:0] mod_q, mod_eff;
  mar_pkg::head_t           head;
  logic                     pop;

  // Modulus register; zero behaves as one.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= mar_pkg::ModW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      mod_q <= cfg_modulus_i;
    end
  end

  assign mod_eff = (mod_q == '0) ? mar_pkg::ModW'(1) : mod_q;

  mar_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .pop_i       (pop),
    .head_o      (head)
  );

  mar_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mod_i       (mod_eff),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result_o)
  );

  // Every delivered result is a proper residue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (result_o < mod_eff))
    else $error("result not below modulus");

  // A full queue always presents a head beat to the back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> head.vld)
    else $error("queue full but head empty");

  // A configuration beat lands in the modulus register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |=> (mod_q == $past(cfg_modulus_i)))
    else $error("modulus write lost");

endmodule

// ===== bench/modular_add_sub_mul_top_test.sv =====
`timescale 1ns / 1ps

module modular_add_sub_mul_top_test;

  typedef struct {
    mar_pkg::op_e op;
    logic [31:0]  a;
    logic [31:0]  b;
  } arith_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  operation_i = '0;
  logic [31:0] operand_a_i = '0;
  logic [31:0] operand_b_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [30:0] result_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [30:0] cfg_modulus_i = 31'd1;

  modular_add_sub_mul_top uut (.*);

  arith_req_t  req_q[$];
  logic [30:0] residue_q[$];
  logic [30:0] cur_modulus = 31'd1;
  int          fail_count = 0;
  int          cycle_count = 0;
  bit          calm = 1'b0;
  int          in_gap = 0;
  int          out_gap = 0;
  bit          cfg_req = 1'b0;
  logic [30:0] cfg_value;
  bit          cfg_done = 1'b0;

  // Clock generation.
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Floored residue of a 32-bit two's complement value.
  function automatic logic [62:0] floor_res(logic [31:0] v, logic [62:0] m);
    logic [62:0] mag;
    logic [62:0] r;
    if (!v[31]) return {31'd0, v} % m;
    mag = {31'd0, (~v) + 32'd1};
    if (mag == 0) mag = 63'h8000_0000;
    r = mag % m;
    return (r == 0) ? 63'd0 : m - r;
  endfunction

  function automatic logic [30:0] modular_result(arith_req_t r, logic [30:0] modv);
    logic [62:0] m;
    logic [62:0] ra;
    logic [62:0] rb;
    logic [62:0] res;
    m  = (modv == 0) ? 63'd1 : {32'd0, modv};
    ra = floor_res(r.a, m);
    rb = floor_res(r.b, m);
    case (r.op)
      mar_pkg::OpAdd: res = (ra + rb) % m;
      mar_pkg::OpSub: res = (ra + m - rb) % m;
      mar_pkg::OpMul: res = (ra * rb) % m;
      default:        res = ra;
    endcase
    return res[30:0];
  endfunction

  // Driver: presents queued beats, inserts random idle bursts and drives output stalls and configuration writes.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        residue_q.push_back(modular_result('{mar_pkg::op_e'(operation_i), operand_a_i,
                                             operand_b_i}, cur_modulus));
        req_q.pop_front();
      end
      if (in_valid_i && in_stall_o) begin
        // Hold the stalled beat.
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        in_gap <= $urandom_range(0, 5);
        in_valid_i <= 1'b0;
      end else if (req_q.size() > 0) begin
        in_valid_i  <= 1'b1;
        operation_i <= req_q[0].op;
        operand_a_i <= req_q[0].a;
        operand_b_i <= req_q[0].b;
      end else begin
        in_valid_i <= 1'b0;
      end
      // Output stall bursts.
      if (out_gap > 0) begin
        out_gap     <= out_gap - 1;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_gap     <= $urandom_range(0, 5);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
      // Configuration write channel.
      if (cfg_valid_i && cfg_ready_o) begin
        cur_modulus <= cfg_modulus_i;
        cfg_valid_i <= 1'b0;
        cfg_done <= 1'b1;
      end else if (cfg_req && !cfg_done && !cfg_valid_i) begin
        cfg_valid_i   <= 1'b1;
        cfg_modulus_i <= cfg_value;
      end
      if (!cfg_req) cfg_done <= 1'b0;
    end
  end

  // Monitor: compares each result beat with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (residue_q.size() == 0) begin
        $error("unexpected result beat: result actual %0d", result_o);
        fail_count <= fail_count + 1;
      end else begin
        if (result_o !== residue_q[0]) begin
          $error("result mismatch: expected %0d actual %0d", residue_q[0], result_o);
          fail_count <= fail_count + 1;
        end
        residue_q.pop_front();
      end
    end
  end

  // Run timeout.
  always @(posedge clk_i) begin
    if (cycle_count > 400000) begin
      $display("modular_add_sub_mul_top test failed");
      $finish;
    end
  end

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 20) - 10;
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_idle();
    while (req_q.size() > 0 || in_valid_i || residue_q.size() > 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic write_modulus(logic [30:0] v);
    cfg_value = v;
    cfg_req = 1'b1;
    while (!cfg_done) @(posedge clk_i);
    cfg_req = 1'b0;
    @(posedge clk_i);
  endtask

  task automatic push_req(mar_pkg::op_e op, logic [31:0] a, logic [31:0] b);
    arith_req_t r;
    r.op = op;
    r.a  = a;
    r.b  = b;
    req_q.push_back(r);
  endtask

  // Stimulus: directed corners, then random phases over several moduli.
  initial begin
    logic [30:0] mods[6];
    repeat (4) @(posedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);
    // Directed beats at the reset modulus of one, then at the largest modulus.
    push_req(mar_pkg::OpAdd, 32'd5, 32'd7);
    push_req(mar_pkg::OpReduce, 32'hFFFF_FFFF, 32'd0);
    wait_idle();
    write_modulus(31'h7FFF_FFFF);
    for (int o = 0; o < 4; o++) begin
      push_req(mar_pkg::op_e'(o), 32'h8000_0000, 32'h7FFF_FFFF);
      push_req(mar_pkg::op_e'(o), 32'hFFFF_FFFF, 32'h8000_0000);
      push_req(mar_pkg::op_e'(o), 32'h7FFF_FFFE, 32'h7FFF_FFFE);
    end
    wait_idle();
    // A zero modulus behaves as one.
    write_modulus(31'd0);
    push_req(mar_pkg::OpMul, 32'd123, 32'hFFFF_FF00);
    push_req(mar_pkg::OpSub, 32'd1, 32'd2);
    wait_idle();
    mods = '{31'd1, 31'd2, 31'd7, 31'h7FFF_FFFF, 31'd65521, 31'h0};
    for (int p = 0; p < 8; p++) begin
      logic [30:0] mv;
      mv = (p < 5) ? mods[p] : 31'($urandom);
      if (p == 7) mv = 31'h4000_0001;
      write_modulus(mv);
      if (p == 7) calm = 1'b1;
      for (int i = 0; i < 200; i++) begin
        push_req(mar_pkg::op_e'($urandom_range(0, 3)), rand_operand(), rand_operand());
      end
      wait_idle();
    end
    if (fail_count == 0) begin
      $display("modular_add_sub_mul_top test passed");
    end else begin
      $display("modular_add_sub_mul_top test failed");
    end
    $finish;
  end

endmodule
